// ===== rtl/pfla_pkg.sv =====
package pfla_pkg;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int PAGE_W = 10;
  localparam int CNT_W  = 11;
  localparam int SIZE_W = 25;
  localparam int OFS_W  = 34;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Built pool capacity; page and count fields are sized for it
  localparam int MAX_PAGES = 1024;

  // Register reset values and limits
  localparam logic [CNT_W-1:0]  PAGES_RESET     = 11'd1024;
  localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 25'd16384;
  localparam logic [SIZE_W-1:0] PAGE_SIZE_LIMIT = 25'd16777216;

  // Register indexes
  typedef enum logic {
    REG_PAGES_IN_USE = 1'b0,
    REG_PAGE_SIZE    = 1'b1
  } reg_idx_t;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_t;

endpackage

// ===== rtl/pfla_stack_ram.sv =====
module pfla_stack_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 10,
  parameter int AW     = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds data while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/page_free_list_allocator_unit.sv =====
// An accepted request is registered in stage B, where the stack RAM is read, and then moves
// into the output register, which holds out_valid high until out_ready takes the result.
// Throughput: one request per cycle; stage B (stack RAM read) and the output register each
// hold one request, and in_ready drops only while both are full and out_ready is low.
// Reset (synchronous, rst high): registers return to 1024 pages of 16384 bytes and the
// pool restarts; untouched stack entries read as their own index via a low-water mark,
// so there is no clearing pass and requests are taken as soon as reset is released.
module page_free_list_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfla_pkg::ADDR_W-1:0]  paddr,
  input  logic [pfla_pkg::DATA_W-1:0]  pwdata,
  output logic [pfla_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pfla_pkg::OP_W-1:0]    operation,
  input  logic [pfla_pkg::PAGE_W-1:0]  page_id,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [pfla_pkg::PAGE_W-1:0]  granted_page,
  output logic [pfla_pkg::OFS_W-1:0]   byte_offset,
  output logic [pfla_pkg::CNT_W-1:0]   free_pages
);

  localparam int MAX_PAGES = pfla_pkg::MAX_PAGES;
  localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int MUL_W = (PW > pfla_pkg::PAGE_W) ? PW : pfla_pkg::PAGE_W;
  localparam int CW    = pfla_pkg::CNT_W;

  // Clamp page count to built capacity
  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (32'(v) > MAX_PAGES) begin
      r = CW'(MAX_PAGES);
    end
    return r;
  endfunction

  // Configuration registers
  logic [CW-1:0]               pages_in_use;
  logic [pfla_pkg::SIZE_W-1:0] page_size_bytes;
  logic                        cfg_wr;
  logic [pfla_pkg::SIZE_W-1:0] size_wr;
  logic [CW-1:0]               cfg_count;
  pfla_pkg::reg_idx_t          cfg_idx;

  // Stack control
  logic [CW-1:0] stack_top, stack_top_next;
  logic [CW-1:0] low_mark, low_mark_next;
  logic [CW-1:0] count_eff;

  // Stage A decode
  pfla_pkg::op_t     a_op;
  pfla_pkg::status_t a_status;
  logic [pfla_pkg::PAGE_W-1:0] a_page;
  logic              a_pop, a_from_mem, a_offs_en;
  logic [CW-1:0]     pop_idx;
  logic              a_accept;
  logic              wr_en, rd_en;

  // Stage B
  logic              b_valid;
  pfla_pkg::status_t b_status;
  logic [pfla_pkg::PAGE_W-1:0] b_page;
  logic              b_pop, b_from_mem, b_offs_en;
  logic [PW-1:0]     b_idx;
  logic [CW-1:0]     b_free;
  logic [PW-1:0]     rd_data;
  logic [PW-1:0]     pop_page;
  logic [MUL_W-1:0]  sel_page;
  logic [MUL_W+pfla_pkg::SIZE_W-1:0] product;
  logic              c_load;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pfla_pkg::reg_idx_t'(paddr[2]);
  assign size_wr = (pwdata[pfla_pkg::SIZE_W-1:0] > pfla_pkg::PAGE_SIZE_LIMIT)
                   ? pfla_pkg::PAGE_SIZE_LIMIT : pwdata[pfla_pkg::SIZE_W-1:0];
  assign cfg_count = (cfg_idx == pfla_pkg::REG_PAGES_IN_USE)
                     ? clamp_count(pwdata[CW-1:0]) : count_eff;

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      pfla_pkg::REG_PAGES_IN_USE: prdata = pfla_pkg::DATA_W'(pages_in_use);
      pfla_pkg::REG_PAGE_SIZE:    prdata = pfla_pkg::DATA_W'(page_size_bytes);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use    <= pfla_pkg::PAGES_RESET;
      page_size_bytes <= pfla_pkg::PAGE_SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pfla_pkg::REG_PAGES_IN_USE: pages_in_use    <= pwdata[CW-1:0];
        pfla_pkg::REG_PAGE_SIZE:    page_size_bytes <= size_wr;
        default:                    pages_in_use    <= pages_in_use;
      endcase
    end
  end

  assign count_eff = clamp_count(pages_in_use);

  // Handshake: stage B frees when it moves to the output register
  assign c_load   = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || c_load;
  assign a_accept = in_valid && in_ready;
  assign a_op     = pfla_pkg::op_t'(operation);
  assign pop_idx  = stack_top - CW'(1);

  // Stage A: check request, update stack pointer, issue RAM access
  always_comb begin
    a_status       = pfla_pkg::ST_OK;
    a_page         = page_id;
    a_pop          = 1'b0;
    a_from_mem     = 1'b0;
    a_offs_en      = 1'b0;
    stack_top_next = stack_top;
    low_mark_next  = low_mark;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    unique case (a_op)
      pfla_pkg::OP_ACQUIRE: begin
        a_page = '0;
        if (stack_top == '0 || 32'(stack_top) > MAX_PAGES) begin
          a_status = pfla_pkg::ST_EXHAUSTED;
        end else begin
          a_pop          = 1'b1;
          a_offs_en      = 1'b1;
          rd_en          = a_accept;
          // entries below the low-water mark were never written
          a_from_mem     = (pop_idx >= low_mark);
          stack_top_next = pop_idx;
          if (pop_idx < low_mark) begin
            low_mark_next = pop_idx;
          end
        end
      end
      pfla_pkg::OP_RELEASE: begin
        if (CW'(page_id) >= count_eff) begin
          a_status = pfla_pkg::ST_OUT_OF_RANGE;
        end else if (stack_top >= count_eff) begin
          a_status = pfla_pkg::ST_OVERFLOW;
        end else begin
          wr_en          = a_accept;
          stack_top_next = stack_top + CW'(1);
        end
      end
      pfla_pkg::OP_LOOKUP: begin
        if (CW'(page_id) >= count_eff) begin
          a_status = pfla_pkg::ST_OUT_OF_RANGE;
        end else begin
          a_offs_en = 1'b1;
        end
      end
      pfla_pkg::OP_RESERVED: begin
        a_page = '0;
      end
      default: begin
        a_page = '0;
      end
    endcase
  end

  // Stack pointer and low-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top <= clamp_count(pfla_pkg::PAGES_RESET);
      low_mark  <= clamp_count(pfla_pkg::PAGES_RESET);
    end else if (cfg_wr) begin
      stack_top <= cfg_count;
      low_mark  <= cfg_count;
    end else if (a_accept) begin
      stack_top <= stack_top_next;
      low_mark  <= low_mark_next;
    end
  end

  pfla_stack_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (PW),
    .AW    (PW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (PW'(stack_top)),
    .wr_data (PW'(page_id)),
    .rd_en   (rd_en),
    .rd_addr (PW'(pop_idx)),
    .rd_data (rd_data)
  );

  // Stage B control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_accept) begin
      b_valid <= 1'b1;
    end else if (c_load) begin
      b_valid <= 1'b0;
    end
  end

  // Stage B payload
  always_ff @(posedge clk) begin
    if (a_accept) begin
      b_status   <= a_status;
      b_page     <= a_page;
      b_pop      <= a_pop;
      b_from_mem <= a_from_mem;
      b_offs_en  <= a_offs_en;
      b_idx      <= PW'(pop_idx);
      b_free     <= stack_top_next;
    end
  end

  // Page select and offset multiply
  assign pop_page = b_from_mem ? rd_data : b_idx;
  assign sel_page = b_pop ? MUL_W'(pop_page) : MUL_W'(b_page);
  assign product  = sel_page * page_size_bytes;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      status       <= b_status;
      granted_page <= pfla_pkg::PAGE_W'(sel_page);
      byte_offset  <= b_offs_en ? pfla_pkg::OFS_W'(product) : '0;
      free_pages   <= b_free;
    end
  end

  // Free count never exceeds the configured pool
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    stack_top <= count_eff)
    else $error("stack_top above configured page count");

  // Low-water mark never above the stack pointer
  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= stack_top)
    else $error("low-water mark above stack_top");

  // Failed requests carry no offset
  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pfla_pkg::ST_OK) |-> byte_offset == '0)
    else $error("nonzero offset on failed request");

  // A pop lowers the stack pointer by one unless a register write is taken at the same time
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (a_accept && a_pop && !cfg_wr) |=> stack_top == $past(stack_top) - CW'(1))
    else $error("pop did not decrement stack_top");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAGES  = pfla_pkg::MAX_PAGES;
  localparam int OP_W       = pfla_pkg::OP_W;
  localparam int PAGE_W     = pfla_pkg::PAGE_W;
  localparam int CNT_W      = pfla_pkg::CNT_W;
  localparam int SIZE_W     = pfla_pkg::SIZE_W;
  localparam int OFS_W      = pfla_pkg::OFS_W;
  localparam int DATA_W     = pfla_pkg::DATA_W;
  localparam int ADDR_W     = pfla_pkg::ADDR_W;
  localparam int IDLE_LIMIT = 4000;
  localparam int SEG_ITEMS  = 84;

  // One expected result of the pool
  typedef struct packed {
    pfla_pkg::status_t  status;
    logic [PAGE_W-1:0]  page;
    logic [OFS_W-1:0]   offset;
    logic [CNT_W-1:0]   free;
  } page_result_t;

  // Mirror of the page pool plus the queue of results still owed by the block
  class page_pool_tracker;
    logic [PAGE_W-1:0] page_stack [MAX_PAGES];
    logic [CNT_W-1:0]  free_top;
    logic [CNT_W-1:0]  pool_pages;
    logic [SIZE_W-1:0] page_bytes;
    page_result_t      owed_results [$];
    int                mismatches;
    int                checked;
    int                status_seen [4];

    function new();
      pool_pages = pfla_pkg::PAGES_RESET;
      page_bytes = pfla_pkg::PAGE_SIZE_RESET;
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
    endfunction

    function logic [CNT_W-1:0] live_pages();
      return (pool_pages > MAX_PAGES) ? CNT_W'(MAX_PAGES) : pool_pages;
    endfunction

    function void restart();
      for (int i = 0; i < MAX_PAGES; i++) page_stack[i] = PAGE_W'(i);
      free_top = live_pages();
    endfunction

    function logic [OFS_W-1:0] offset_of(logic [PAGE_W-1:0] pg);
      logic [63:0] prod;
      prod = 64'(pg) * 64'(page_bytes);
      return prod[OFS_W-1:0];
    endfunction

    // Register write restarts the pool; page size saturates at its limit
    function void write_register(pfla_pkg::reg_idx_t idx, logic [DATA_W-1:0] data);
      if (idx == pfla_pkg::REG_PAGES_IN_USE) begin
        pool_pages = data[CNT_W-1:0];
      end else begin
        page_bytes = (data[SIZE_W-1:0] > pfla_pkg::PAGE_SIZE_LIMIT)
                     ? pfla_pkg::PAGE_SIZE_LIMIT : data[SIZE_W-1:0];
      end
      restart();
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Accepted request: update the pool and queue what the block must return
    function void note_request(pfla_pkg::op_t op, logic [PAGE_W-1:0] pg);
      page_result_t     r;
      logic [CNT_W-1:0] count;
      count = live_pages();
      r = '0;
      case (op)
        pfla_pkg::OP_ACQUIRE: begin
          if (free_top == 0) begin
            r.status = pfla_pkg::ST_EXHAUSTED;
          end else begin
            free_top = free_top - 1;
            r.page   = page_stack[free_top[PAGE_W-1:0]];
            r.offset = offset_of(r.page);
          end
        end
        pfla_pkg::OP_RELEASE: begin
          r.page = pg;
          if ({1'b0, pg} >= count) begin
            r.status = pfla_pkg::ST_OUT_OF_RANGE;
          end else if (free_top >= count) begin
            r.status = pfla_pkg::ST_OVERFLOW;
          end else begin
            page_stack[free_top[PAGE_W-1:0]] = pg;
            free_top = free_top + 1;
          end
        end
        pfla_pkg::OP_LOOKUP: begin
          r.page = pg;
          if ({1'b0, pg} >= count) r.status = pfla_pkg::ST_OUT_OF_RANGE;
          else r.offset = offset_of(pg);
        end
        default: ;
      endcase
      r.free = free_top;
      owed_results.push_back(r);
    endfunction

    // Accepted result: compare against the oldest owed result
    function void check_result(logic [1:0] st, logic [PAGE_W-1:0] pg,
                               logic [OFS_W-1:0] ofs, logic [CNT_W-1:0] fr);
      page_result_t e;
      checked++;
      status_seen[st]++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result st=%0d page=%0d ofs=%0d free=%0d",
                   $realtime, st, pg, ofs, fr);
        return;
      end
      e = owed_results.pop_front();
      if (st != e.status || pg != e.page || ofs != e.offset || fr != e.free) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp st=%0d page=%0d ofs=%0d free=%0d got st=%0d page=%0d ofs=%0d free=%0d",
                   $realtime, e.status, e.page, e.offset, e.free, st, pg, ofs, fr);
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation = '0;
  logic [PAGE_W-1:0]   page_id   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [PAGE_W-1:0]   granted_page;
  logic [OFS_W-1:0]    byte_offset;
  logic [CNT_W-1:0]    free_pages;

  page_pool_tracker pool;
  int send_idle_pct = 29;
  int recv_idle_pct = 64;
  int requests_sent = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  page_free_list_allocator_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .page_id(page_id),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .granted_page(granted_page), .byte_offset(byte_offset), .free_pages(free_pages)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side backpressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pool.check_result(status, granted_page, byte_offset, free_pages);
  end

  // Watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // APB write: setup then access
  task automatic write_reg(pfla_pkg::reg_idx_t idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    pool.write_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Present one request, with random idle cycles ahead of it
  task automatic send_request(pfla_pkg::op_t op, logic [PAGE_W-1:0] pg);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    page_id   = pg;
    do @(posedge clk); while (!in_ready);
    pool.note_request(op, pg);
    requests_sent++;
  endtask

  // Let the block drain before touching the registers
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pool.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers; upper pwdata bits get random junk half the time
  task automatic set_pool(logic [CNT_W-1:0] pages, logic [SIZE_W-1:0] size);
    logic [DATA_W-1:0] junk;
    drain();
    junk = $urandom_range(0, 1) ? $urandom : '0;
    write_reg(pfla_pkg::REG_PAGES_IN_USE, {junk[DATA_W-1:CNT_W], pages});
    junk = $urandom_range(0, 1) ? $urandom : '0;
    write_reg(pfla_pkg::REG_PAGE_SIZE, {junk[DATA_W-1:SIZE_W], size});
    settings_used++;
  endtask

  // Random request biased toward in-range pages
  task automatic random_request(int live);
    int  pick;
    pfla_pkg::op_t op;
    logic [PAGE_W-1:0] pg;
    pick = $urandom_range(0, 99);
    if (pick < 42)      op = pfla_pkg::OP_ACQUIRE;
    else if (pick < 80) op = pfla_pkg::OP_RELEASE;
    else if (pick < 96) op = pfla_pkg::OP_LOOKUP;
    else                op = pfla_pkg::OP_RESERVED;
    if (live > 0 && $urandom_range(0, 99) < 75) pg = PAGE_W'($urandom_range(0, live - 1));
    else pg = PAGE_W'($urandom);
    send_request(op, pg);
  endtask

  initial begin
    logic [CNT_W-1:0]  seg_pages [6];
    logic [SIZE_W-1:0] seg_size [6];
    int live;

    pool = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, full pool
    send_request(pfla_pkg::OP_ACQUIRE, 10'd0);
    send_request(pfla_pkg::OP_LOOKUP, 10'd0);
    send_request(pfla_pkg::OP_LOOKUP, 10'd1023);
    send_request(pfla_pkg::OP_RELEASE, 10'd1023);
    send_request(pfla_pkg::OP_RELEASE, 10'd5);
    send_request(pfla_pkg::OP_RESERVED, 10'd1023);

    // Directed: three pages, oversized page size saturates
    set_pool(11'd3, 25'h1FFFFFF);
    repeat (4) send_request(pfla_pkg::OP_ACQUIRE, 10'h3FF);
    send_request(pfla_pkg::OP_RELEASE, 10'd3);
    send_request(pfla_pkg::OP_RELEASE, 10'd1023);
    send_request(pfla_pkg::OP_RELEASE, 10'd1);
    send_request(pfla_pkg::OP_RELEASE, 10'd1);
    send_request(pfla_pkg::OP_RELEASE, 10'd0);
    send_request(pfla_pkg::OP_RELEASE, 10'd2);
    send_request(pfla_pkg::OP_ACQUIRE, 10'd0);
    send_request(pfla_pkg::OP_LOOKUP, 10'd2);
    send_request(pfla_pkg::OP_LOOKUP, 10'd3);

    // Directed: empty pool, zero page size
    set_pool(11'd0, 25'd0);
    send_request(pfla_pkg::OP_ACQUIRE, 10'd0);
    send_request(pfla_pkg::OP_RELEASE, 10'd0);
    send_request(pfla_pkg::OP_LOOKUP, 10'd0);

    // Directed: page count above capacity clamps, one-byte pages
    set_pool(11'd2047, 25'd1);
    send_request(pfla_pkg::OP_LOOKUP, 10'd1023);
    send_request(pfla_pkg::OP_ACQUIRE, 10'd0);

    // Random segments over several pool settings
    seg_pages[0] = 11'd1;
    seg_size[0]  = 25'd1;
    seg_pages[1] = CNT_W'($urandom_range(2, 8));
    seg_size[1]  = SIZE_W'($urandom);
    seg_pages[2] = 11'd16;
    seg_size[2]  = pfla_pkg::PAGE_SIZE_LIMIT;
    seg_pages[3] = CNT_W'($urandom_range(9, 32));
    seg_size[3]  = 25'd0;
    seg_pages[4] = 11'd2047;
    seg_size[4]  = 25'h1FFFFFF;
    seg_pages[5] = CNT_W'($urandom_range(1, 12));
    seg_size[5]  = SIZE_W'($urandom_range(1, 4096));

    for (int s = 0; s < 6; s++) begin
      set_pool(seg_pages[s], seg_size[s]);
      if (s == 2) begin
        send_idle_pct = 64;
        recv_idle_pct = 29;
      end else if (s == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      live = (seg_pages[s] > MAX_PAGES) ? MAX_PAGES : int'(seg_pages[s]);
      repeat (SEG_ITEMS) random_request(live);
    end

    // Wind down
    drain();
    repeat (10) @(posedge clk);

    $display("%0d requests over %0d pool settings, %0d results checked, %0d mismatches",
             requests_sent, settings_used, pool.checked, pool.mismatches);
    $display("status mix: ok %0d, exhausted %0d, out of range %0d, overflow %0d",
             pool.status_seen[pfla_pkg::ST_OK], pool.status_seen[pfla_pkg::ST_EXHAUSTED],
             pool.status_seen[pfla_pkg::ST_OUT_OF_RANGE],
             pool.status_seen[pfla_pkg::ST_OVERFLOW]);
    if (pool.mismatches == 0 && pool.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
